FILE: rtl/lpcc_pkg.sv
`timescale 1ns / 1ps

package lpcc_pkg;

  localparam int GUARD_BITS   = 24;
  localparam int ATAN_ENTRIES = 24;
  localparam int REG_IDX_W    = 3;
  localparam int ACC_W        = 32;

  localparam logic [REG_IDX_W-1:0] REG_CROP_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CROP_OUTSIDE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A_LOW        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A_HIGH       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_B_LOW        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_B_HIGH       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_C_LOW        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_C_HIGH       = 3'd7;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_CARTESIAN = 2'd1,
    MODE_SPHERICAL = 2'd2,
    MODE_CYLINDRIC = 2'd3
  } mode_t;

  typedef struct packed {
    logic az_ok;
    logic r_lo;
    logic r_hi;
    logic cart_in;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    logic   z_zero;
    logic   h_zero;
    logic   z_neg;
  } elev_side_t;

  function automatic logic [ACC_W-1:0] lpcc_atan(input int i);
    logic [ACC_W-1:0] v;
    case (i)
      0:  v = 32'd294912000;
      1:  v = 32'd174096719;
      2:  v = 32'd91987925;
      3:  v = 32'd46694507;
      4:  v = 32'd23437865;
      5:  v = 32'd11730358;
      6:  v = 32'd5866610;
      7:  v = 32'd2933484;
      8:  v = 32'd1466764;
      9:  v = 32'd733385;
      10: v = 32'd366693;
      11: v = 32'd183346;
      12: v = 32'd91673;
      13: v = 32'd45837;
      14: v = 32'd22918;
      15: v = 32'd11459;
      16: v = 32'd5730;
      17: v = 32'd2865;
      18: v = 32'd1432;
      19: v = 32'd716;
      20: v = 32'd358;
      21: v = 32'd179;
      22: v = 32'd90;
      23: v = 32'd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/lidar_point_crop_classifier.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// config   | in        | cfg_write               | cfg_index, cfg_data
// points   | in        | in_valid / in_stall     | point_x, point_y, point_z, azimuth
// results  | out       | out_valid / out_stall   | drop_point
//
// One point enters per cycle while in_stall is low; the pipeline depth is set by the
// square-root stages (one root bit each) and the elevation stages.
// Synchronous reset clears the configuration registers and all stage valid bits.
// A stalled result freezes the whole pipeline, and in_stall follows it in the same cycle.

module lidar_point_crop_classifier #(
  parameter int COORD_BITS       = 21,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lpcc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   point_x,
  input  logic signed [COORD_BITS-1:0]   point_y,
  input  logic signed [COORD_BITS-1:0]   point_z,
  input  logic [15:0]                    azimuth,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           drop_point
);

  import lpcc_pkg::*;

  localparam int B   = COORD_BITS;
  localparam int CW  = 34;
  localparam int NIT = (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS : ATAN_ENTRIES;
  localparam int XW  = B + GUARD_BITS + 4;
  localparam int SQ_SIDE_W = B + $bits(flags_t);
  localparam longint unsigned RMAX_L  = (64'd1 << (B - 1)) - 64'd1;
  localparam longint unsigned RMAX2_L = RMAX_L * RMAX_L;
  localparam logic [2*B:0]          RMAX2  = (2*B+1)'(RMAX2_L);
  localparam logic signed [B-1:0]   RMAX_S = {1'b0, {(B-1){1'b1}}};
  localparam logic signed [15:0]    EL_MAX = 16'sd9000;
  localparam logic signed [15:0]    EL_MIN = -16'sd9000;

  mode_t                crop_mode;
  logic                 crop_outside;
  logic signed [B-1:0]  bound_a_low, bound_a_high;
  logic signed [B-1:0]  bound_b_low, bound_b_high;
  logic signed [B-1:0]  bound_c_low, bound_c_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_mode    <= MODE_OFF;
      crop_outside <= 1'b0;
      bound_a_low  <= '0;
      bound_a_high <= '0;
      bound_b_low  <= '0;
      bound_b_high <= '0;
      bound_c_low  <= '0;
      bound_c_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CROP_MODE:    crop_mode    <= mode_t'(cfg_data[1:0]);
        REG_CROP_OUTSIDE: crop_outside <= cfg_data[0];
        REG_A_LOW:        bound_a_low  <= cfg_data;
        REG_A_HIGH:       bound_a_high <= cfg_data;
        REG_B_LOW:        bound_b_low  <= cfg_data;
        REG_B_HIGH:       bound_b_high <= cfg_data;
        REG_C_LOW:        bound_c_low  <= cfg_data;
        REG_C_HIGH:       bound_c_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic                v0;
  logic signed [B-1:0] x0, y0, z0;
  logic [15:0]         az0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= point_x;
      y0  <= point_y;
      z0  <= point_z;
      az0 <= azimuth;
    end
  end

  logic [B-1:0]         mx, my, mz;
  logic signed [CW-1:0] az_s, al_s, ah_s;
  flags_t               fl_next1;

  assign mx   = x0[B-1] ? (~x0 + 1'b1) : x0;
  assign my   = y0[B-1] ? (~y0 + 1'b1) : y0;
  assign mz   = z0[B-1] ? (~z0 + 1'b1) : z0;
  assign az_s = $signed({{(CW-16){1'b0}}, az0});
  assign al_s = CW'(bound_a_low);
  assign ah_s = CW'(bound_a_high);

  always_comb begin
    fl_next1.cart_in = (x0 >= bound_a_low) && (x0 <= bound_a_high) &&
                       (y0 >= bound_b_low) && (y0 <= bound_b_high) &&
                       (z0 >= bound_c_low) && (z0 <= bound_c_high);
    if (al_s <= ah_s) begin
      fl_next1.az_ok = (az_s >= al_s) && (az_s <= ah_s);
    end else begin
      fl_next1.az_ok = (az_s >= al_s) || (az_s <= ah_s);
    end
    fl_next1.r_lo = 1'b0;
    fl_next1.r_hi = 1'b0;
  end

  logic                v1;
  logic [2*B-1:0]      sqx1, sqy1, sqz1, cl_sq1, ch_sq1;
  logic signed [B-1:0] z1;
  flags_t              fl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1   <= (2*B)'(mx) * (2*B)'(mx);
      sqy1   <= (2*B)'(my) * (2*B)'(my);
      sqz1   <= (2*B)'(mz) * (2*B)'(mz);
      cl_sq1 <= (2*B)'(unsigned'(bound_c_low)) * (2*B)'(unsigned'(bound_c_low));
      ch_sq1 <= (2*B)'(unsigned'(bound_c_high)) * (2*B)'(unsigned'(bound_c_high));
      z1     <= z0;
      fl1    <= fl_next1;
    end
  end

  logic [2*B-1:0] hsq;
  logic [2*B:0]   rsq;
  logic           sat;
  flags_t         fl_next2;

  assign hsq = sqx1 + sqy1;
  assign rsq = (2*B+1)'(hsq) + (2*B+1)'(sqz1);
  assign sat = rsq > RMAX2;

  always_comb begin
    fl_next2 = fl1;
    fl_next2.r_lo = (bound_c_low <= 0) || sat || (rsq >= (2*B+1)'(cl_sq1));
    if (sat) begin
      fl_next2.r_hi = bound_c_high == RMAX_S;
    end else begin
      fl_next2.r_hi = !bound_c_high[B-1] && (rsq <= (2*B+1)'(ch_sq1));
    end
  end

  logic                v2;
  logic [2*B-1:0]      hsq2;
  logic signed [B-1:0] z2;
  flags_t              fl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsq2 <= hsq;
      z2   <= z1;
      fl2  <= fl_next2;
    end
  end

  logic                 sq_valid;
  logic [B-1:0]         sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic signed [B-1:0]  sq_z;
  flags_t               sq_fl;
  elev_side_t           cd_side_in;

  lpcc_sqrt #(
    .W      (B),
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_val    (hsq2),
    .in_side   ({z2, fl2}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_z  = $signed(sq_side[SQ_SIDE_W-1:$bits(flags_t)]);
  assign sq_fl = flags_t'(sq_side[$bits(flags_t)-1:0]);

  always_comb begin
    cd_side_in.flags  = sq_fl;
    cd_side_in.z_zero = sq_z == '0;
    cd_side_in.h_zero = sq_root == '0;
    cd_side_in.z_neg  = sq_z[B-1];
  end

  logic                    cd_valid;
  logic signed [ACC_W-1:0] cd_acc;
  elev_side_t              cd_side;

  lpcc_cordic #(
    .N      (NIT),
    .HW     (B),
    .XW     (XW),
    .SIDE_W ($bits(elev_side_t))
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_h      (sq_root),
    .in_z      (sq_z),
    .in_side   (cd_side_in),
    .out_valid (cd_valid),
    .out_acc   (cd_acc),
    .out_side  (cd_side)
  );

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [15:0]      el_rnd;
  logic signed [15:0]      el_next;

  assign acc_rnd = cd_acc + 32'sd32768;
  assign el_rnd  = $signed(acc_rnd[31:16]);

  always_comb begin
    if (cd_side.z_zero) begin
      el_next = '0;
    end else if (cd_side.h_zero) begin
      el_next = cd_side.z_neg ? EL_MIN : EL_MAX;
    end else if (el_rnd > EL_MAX) begin
      el_next = EL_MAX;
    end else if (el_rnd < EL_MIN) begin
      el_next = EL_MIN;
    end else begin
      el_next = el_rnd;
    end
  end

  logic               ev;
  logic signed [15:0] el;
  flags_t             efl;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else if (en) begin
      ev <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      el  <= el_next;
      efl <= cd_side.flags;
    end
  end

  logic signed [CW-1:0] el_s, bl_s, bh_s;
  logic                 in_bounds;
  logic                 drop_next;

  assign el_s = CW'(el);
  assign bl_s = CW'(bound_b_low);
  assign bh_s = CW'(bound_b_high);

  always_comb begin
    case (crop_mode)
      MODE_CARTESIAN: begin
        in_bounds = efl.cart_in;
        drop_next = in_bounds == crop_outside;
      end
      MODE_SPHERICAL: begin
        in_bounds = efl.az_ok && efl.r_lo && efl.r_hi && (el_s > bl_s) && (el_s < bh_s);
        drop_next = in_bounds == crop_outside;
      end
      default: begin
        in_bounds = 1'b0;
        drop_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drop_point <= drop_next;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output stage is empty");

  a_elevation_range: assert property (@(posedge clk) disable iff (rst)
    ev |-> (el <= EL_MAX) && (el >= EL_MIN))
    else $error("elevation outside the clamp range");

endmodule

FILE: rtl/lpcc_sqrt.sv
`timescale 1ns / 1ps

module lpcc_sqrt #(
  parameter int W      = 21,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [W];
  logic [2*W-1:0]    rem  [W];
  logic [W-1:0]      root [W];
  logic [SIDE_W-1:0] side [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int J = W - 1 - s;
    logic              v_in;
    logic [2*W-1:0]    rem_in;
    logic [W-1:0]      root_in;
    logic [SIDE_W-1:0] side_in;
    logic [2*W:0]      trial;
    logic              take;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign rem_in  = rem[s-1];
      assign root_in = root[s-1];
      assign side_in = side[s-1];
    end

    assign trial = ((2*W+1)'(root_in) << (J + 1)) | ((2*W+1)'(1) << (2 * J));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s] <= side_in;
        if (take) begin
          rem[s]  <= rem_in - (2*W)'(trial);
          root[s] <= root_in | (W'(1) << J);
        end else begin
          rem[s]  <= rem_in;
          root[s] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld[W-1];
  assign out_root  = root[W-1];
  assign out_side  = side[W-1];

endmodule

FILE: rtl/lpcc_cordic.sv
`timescale 1ns / 1ps

module lpcc_cordic #(
  parameter int N      = 16,
  parameter int HW     = 21,
  parameter int XW     = 49,
  parameter int SIDE_W = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [HW-1:0]                 in_h,
  input  logic signed [HW-1:0]          in_z,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic signed [lpcc_pkg::ACC_W-1:0] out_acc,
  output logic [SIDE_W-1:0]             out_side
);

  import lpcc_pkg::*;

  logic                    vld  [N];
  logic signed [XW-1:0]    xq   [N];
  logic signed [XW-1:0]    yq   [N];
  logic signed [ACC_W-1:0] aq   [N];
  logic [SIDE_W-1:0]       side [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                    v_in;
    logic signed [XW-1:0]    x_in;
    logic signed [XW-1:0]    y_in;
    logic signed [ACC_W-1:0] a_in;
    logic [SIDE_W-1:0]       side_in;
    logic signed [XW-1:0]    xs;
    logic signed [XW-1:0]    ys;
    logic signed [ACC_W-1:0] ang;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = $signed({{(XW-HW-GUARD_BITS){1'b0}}, in_h, {GUARD_BITS{1'b0}}});
      assign y_in    = $signed({{(XW-HW-GUARD_BITS){in_z[HW-1]}}, in_z,
                                {GUARD_BITS{1'b0}}});
      assign a_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[i-1];
      assign x_in    = xq[i-1];
      assign y_in    = yq[i-1];
      assign a_in    = aq[i-1];
      assign side_in = side[i-1];
    end

    assign xs  = x_in >>> i;
    assign ys  = y_in >>> i;
    assign ang = $signed(lpcc_atan(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i] <= side_in;
        if (!y_in[XW-1]) begin
          xq[i] <= x_in + ys;
          yq[i] <= y_in - xs;
          aq[i] <= a_in + ang;
        end else begin
          xq[i] <= x_in - ys;
          yq[i] <= y_in + xs;
          aq[i] <= a_in - ang;
        end
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_acc   = aq[N-1];
  assign out_side  = side[N-1];

endmodule
